>>> design/bmp_palette_image_decoder_macros.svh
// Assertion macros for the bitmap palette decoder.
`ifndef BMP_PALETTE_IMAGE_DECODER_MACROS_SVH
`define BMP_PALETTE_IMAGE_DECODER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BPID_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpid assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define BPID_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpid assertion failed");

`endif

>>> design/bpid_pkg.sv
// Constants shared by the bitmap palette decoder.
`default_nettype none

package bpid_pkg;

    localparam int MAX_DIM_DEF       = 4096;
    localparam int PALETTE_DEPTH_DEF = 256;

    localparam int IDX_W = 24;
    localparam int COL_W = 8;

    localparam logic [31:0] HDR_END = 32'd54;

    localparam logic [31:0] POS_SIG    = 32'd1;
    localparam logic [31:0] POS_OFFSET = 32'd13;
    localparam logic [31:0] POS_HSIZE  = 32'd17;
    localparam logic [31:0] POS_WIDTH  = 32'd21;
    localparam logic [31:0] POS_HEIGHT = 32'd25;
    localparam logic [31:0] POS_BPP    = 32'd29;
    localparam logic [31:0] POS_PCOUNT = 32'd49;
    localparam logic [31:0] POS_CHECK  = 32'd53;

    localparam logic [15:0] SIG_BM      = 16'h4D42;
    localparam logic [31:0] HSIZE_INFO  = 32'd40;
    localparam logic [31:0] HSIZE_CORE  = 32'd12;
    localparam logic [15:0] BPP_PAL_MAX = 16'd8;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_NOT_BM   = 3'd1;
    localparam logic [2:0] STS_BAD_HDR  = 3'd2;
    localparam logic [2:0] STS_OS2      = 3'd3;
    localparam logic [2:0] STS_TOO_BIG  = 3'd4;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [COL_W-1:0] ALPHA_OPAQUE = 8'd255;

endpackage

`default_nettype wire

>>> design/bmp_palette_image_decoder.sv
// A byte transfer that yields a result passes through the read stage and then the output register.
// Throughput: one file byte per cycle while in_ready is high; the palette memory takes one read per byte.
// The output register is the only stall point; input stalls only when it and the
// read stage are both full. Reset clears the parser to the header stage and all
// palette valid bits at once; no clearing pass. A first_byte transfer does the same.
`default_nettype none

module bmp_palette_image_decoder
    import bpid_pkg::*;
#(
    parameter int MAX_DIM       = MAX_DIM_DEF,
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       file_byte,
    input  wire logic             first_byte,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  kind,
    output logic [2:0]            status,
    output logic [IDX_W-1:0]      pixel_index,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue,
    output logic [7:0]            alpha,
    output logic                  last
);

    localparam int DIM_W = $clog2(MAX_DIM + 2);
    localparam int PE_W  = $clog2(PALETTE_DEPTH + 2);
    localparam int PA_W  = $clog2(PALETTE_DEPTH);

    localparam logic [2:0] ST_HEADER  = 3'd0;
    localparam logic [2:0] ST_PALETTE = 3'd1;
    localparam logic [2:0] ST_GAP     = 3'd2;
    localparam logic [2:0] ST_PIXELS  = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    // parser state
    logic [2:0]       stage_reg, stage_next, stage_cur;
    logic [31:0]      pos_reg, pos_next, pos_cur;
    logic [31:0]      fa_reg, fa_next, fa_cur;
    logic [31:0]      dofs_reg, dofs_next, dofs_cur;
    logic [DIM_W-1:0] width_reg, width_next, width_cur;
    logic [DIM_W-1:0] height_reg, height_next, height_cur;
    logic [15:0]      bpp_reg, bpp_next, bpp_cur;
    logic [PE_W-1:0]  pe_reg, pe_next, pe_cur;
    logic [DIM_W-1:0] col_reg, col_next, col_cur;
    logic [DIM_W-1:0] row_reg, row_next, row_cur;
    logic [IDX_W-1:0] base_reg, base_next, base_cur;
    logic [7:0]       pblue_reg, pblue_next;
    logic [7:0]       pgreen_reg, pgreen_next;

    // palette memory and valid bits
    logic [23:0]              pal_mem [PALETTE_DEPTH];
    logic [23:0]              pal_rd_reg;
    logic [PALETTE_DEPTH-1:0] pal_vld_reg;
    logic                     pal_we;
    logic [PA_W-1:0]          pal_waddr;
    logic [PA_W-1:0]          rd_addr;
    logic                     in_range;

    // read stage
    logic             s1_vld_reg;
    logic             s1_kind_reg;
    logic [2:0]       s1_status_reg;
    logic [IDX_W-1:0] s1_index_reg;
    logic             s1_last_reg;
    logic             s1_hit_reg;

    // output stage
    logic             out_vld_reg;
    logic             out_kind_reg;
    logic [2:0]       out_status_reg;
    logic [IDX_W-1:0] out_index_reg;
    logic [23:0]      out_rgb_reg;
    logic             out_last_reg;

    logic             in_acc;
    logic             out_free;
    logic             s1_move;
    logic             res_vld;
    logic             res_kind;
    logic [2:0]       res_status;
    logic [IDX_W-1:0] res_index;
    logic             res_last;

    logic [31:0]        fa_new;
    logic [31:0]        pcount;
    logic [31:0]        rel;
    logic [2*DIM_W-1:0] base_prod;
    logic               do_pix;
    logic               end_row;
    logic               fin;

    assign out_free = !out_vld_reg || out_ready;
    assign in_ready = !s1_vld_reg || out_free;
    assign in_acc   = in_valid && in_ready;
    assign s1_move  = s1_vld_reg && out_free;

    assign in_range = ({1'b0, file_byte} < 9'(PALETTE_DEPTH));
    assign rd_addr  = in_range ? file_byte[PA_W-1:0] : '0;

    always_comb
    begin
        stage_cur  = first_byte ? ST_HEADER : stage_reg;
        pos_cur    = first_byte ? '0 : pos_reg;
        fa_cur     = first_byte ? '0 : fa_reg;
        dofs_cur   = first_byte ? '0 : dofs_reg;
        width_cur  = first_byte ? '0 : width_reg;
        height_cur = first_byte ? '0 : height_reg;
        bpp_cur    = first_byte ? '0 : bpp_reg;
        pe_cur     = first_byte ? '0 : pe_reg;
        col_cur    = first_byte ? '0 : col_reg;
        row_cur    = first_byte ? '0 : row_reg;
        base_cur   = first_byte ? '0 : base_reg;

        stage_next  = stage_cur;
        pos_next    = pos_cur + 32'd1;
        fa_next     = fa_cur;
        dofs_next   = dofs_cur;
        width_next  = width_cur;
        height_next = height_cur;
        bpp_next    = bpp_cur;
        pe_next     = pe_cur;
        col_next    = col_cur;
        row_next    = row_cur;
        base_next   = base_cur;
        pblue_next  = pblue_reg;
        pgreen_next = pgreen_reg;

        res_vld    = 1'b0;
        res_kind   = KIND_PIXEL;
        res_status = STS_OK;
        res_index  = '0;
        res_last   = 1'b0;
        pal_we     = 1'b0;

        fa_new    = {file_byte, fa_cur[31:8]};
        pcount    = (fa_new == 32'd0 && bpp_cur <= BPP_PAL_MAX)
                    ? (32'd1 << bpp_cur[3:0]) : fa_new;
        rel       = pos_cur - HDR_END;
        pal_waddr = rel[PA_W+1:2];
        base_prod = {{DIM_W{1'b0}}, height_cur - DIM_W'(1)} * {{DIM_W{1'b0}}, width_cur};

        do_pix  = (stage_cur == ST_PIXELS) || (stage_cur == ST_GAP && pos_cur == dofs_cur);
        end_row = ({1'b0, col_cur} + (DIM_W+1)'(1)) >= {1'b0, width_cur};
        fin     = end_row && (({1'b0, row_cur} + (DIM_W+1)'(1)) >= {1'b0, height_cur});

        case (stage_cur)
            ST_HEADER:
            begin
                fa_next = fa_new;
                case (pos_cur)
                    POS_SIG:
                    begin
                        if (fa_new[31:16] != SIG_BM)
                        begin
                            res_vld    = 1'b1;
                            res_status = STS_NOT_BM;
                        end
                    end
                    POS_OFFSET: dofs_next = fa_new;
                    POS_HSIZE:
                    begin
                        if (fa_new == HSIZE_CORE)
                        begin
                            res_vld    = 1'b1;
                            res_status = STS_OS2;
                        end
                        else if (fa_new != HSIZE_INFO)
                        begin
                            res_vld    = 1'b1;
                            res_status = STS_BAD_HDR;
                        end
                    end
                    POS_WIDTH:
                        width_next = (fa_new > 32'(MAX_DIM))
                                     ? DIM_W'(MAX_DIM + 1) : fa_new[DIM_W-1:0];
                    POS_HEIGHT:
                        height_next = (fa_new > 32'(MAX_DIM))
                                      ? DIM_W'(MAX_DIM + 1) : fa_new[DIM_W-1:0];
                    POS_BPP: bpp_next = fa_new[31:16];
                    POS_PCOUNT:
                        pe_next = (pcount > 32'(PALETTE_DEPTH))
                                  ? PE_W'(PALETTE_DEPTH + 1) : pcount[PE_W-1:0];
                    POS_CHECK:
                    begin
                        if (width_cur > DIM_W'(MAX_DIM) || height_cur > DIM_W'(MAX_DIM)
                            || pe_cur > PE_W'(PALETTE_DEPTH)
                            || dofs_cur < (HDR_END + 32'({pe_cur, 2'b00})))
                        begin
                            res_vld    = 1'b1;
                            res_status = STS_TOO_BIG;
                        end
                        else if (width_cur == '0 || height_cur == '0)
                        begin
                            res_vld    = 1'b1;
                            res_status = STS_OK;
                        end
                        else
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            base_next  = IDX_W'(base_prod);
                            stage_next = (pe_cur != '0) ? ST_PALETTE : ST_GAP;
                        end
                    end
                    default: ;
                endcase
                if (res_vld)
                begin
                    res_kind   = KIND_STATUS;
                    res_last   = 1'b1;
                    stage_next = ST_DONE;
                end
            end
            ST_PALETTE:
            begin
                case (rel[1:0])
                    2'd0:    pblue_next  = file_byte;
                    2'd1:    pgreen_next = file_byte;
                    2'd2:    pal_we      = 1'b1;
                    default: ;
                endcase
                if ((rel + 32'd1) >= 32'({pe_cur, 2'b00}))
                    stage_next = ST_GAP;
            end
            ST_GAP, ST_PIXELS:
            begin
                if (do_pix)
                begin
                    res_vld   = 1'b1;
                    res_index = base_cur + IDX_W'(col_cur);
                    res_last  = fin;
                    if (fin)
                        stage_next = ST_DONE;
                    else
                    begin
                        stage_next = ST_PIXELS;
                        if (end_row)
                        begin
                            col_next  = '0;
                            row_next  = row_cur + DIM_W'(1);
                            base_next = base_cur - IDX_W'(width_cur);
                        end
                        else
                            col_next = col_cur + DIM_W'(1);
                    end
                end
            end
            default:
                pos_next = pos_cur;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg   <= ST_HEADER;
            pos_reg     <= '0;
            fa_reg      <= '0;
            dofs_reg    <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            bpp_reg     <= '0;
            pe_reg      <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            base_reg    <= '0;
            pal_vld_reg <= '0;
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                stage_reg  <= stage_next;
                pos_reg    <= pos_next;
                fa_reg     <= fa_next;
                dofs_reg   <= dofs_next;
                width_reg  <= width_next;
                height_reg <= height_next;
                bpp_reg    <= bpp_next;
                pe_reg     <= pe_next;
                col_reg    <= col_next;
                row_reg    <= row_next;
                base_reg   <= base_next;
                if (first_byte)
                    pal_vld_reg <= '0;
                else if (pal_we)
                    pal_vld_reg[pal_waddr] <= 1'b1;
            end
            if (in_acc)
                s1_vld_reg <= res_vld;
            else if (s1_move)
                s1_vld_reg <= 1'b0;
            if (out_free)
                out_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && pal_we)
            pal_mem[pal_waddr] <= {file_byte, pgreen_reg, pblue_reg};
        if (in_acc)
            pal_rd_reg <= pal_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            pblue_reg     <= pblue_next;
            pgreen_reg    <= pgreen_next;
            s1_kind_reg   <= res_kind;
            s1_status_reg <= res_status;
            s1_index_reg  <= res_index;
            s1_last_reg   <= res_last;
            s1_hit_reg    <= in_range && !first_byte && pal_vld_reg[rd_addr];
        end
        if (s1_move)
        begin
            out_kind_reg   <= s1_kind_reg;
            out_status_reg <= s1_status_reg;
            out_index_reg  <= s1_index_reg;
            out_last_reg   <= s1_last_reg;
            out_rgb_reg    <= (s1_hit_reg && s1_kind_reg == KIND_PIXEL) ? pal_rd_reg : '0;
        end
    end

    assign out_valid   = out_vld_reg;
    assign kind        = out_kind_reg;
    assign status      = out_status_reg;
    assign pixel_index = out_index_reg;
    assign red         = out_rgb_reg[23:16];
    assign green       = out_rgb_reg[15:8];
    assign blue        = out_rgb_reg[7:0];
    assign alpha       = (out_kind_reg == KIND_PIXEL) ? ALPHA_OPAQUE : '0;
    assign last        = out_last_reg;

`include "bmp_palette_image_decoder_macros.svh"

    `BPID_ASSERT_NOW(a_stall_holds_read_stage, s1_vld_reg && out_vld_reg && !out_ready, !in_ready)
    `BPID_ASSERT_NEXT(a_done_is_silent, in_acc && !first_byte && stage_reg == ST_DONE, !s1_vld_reg)
    `BPID_ASSERT_NOW(a_pixel_pos_in_frame, stage_reg == ST_PIXELS,
        col_reg < width_reg && row_reg < height_reg)

endmodule

`default_nettype wire
